### hw/rtl/brwf_pkg.sv
// Shared constants, codes and types for the bitmap range write and find-first block.
package brwf_pkg;

  localparam int CAP_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = CAP_BITS / WORD_BITS;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BSEL_W    = $clog2(WORD_BITS);
  localparam int IDX_W     = 12;
  localparam int LEN_W     = 13;
  localparam int FUNC_W    = 3;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 32;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP_BITS);

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 3'd0,
    FN_TEST   = 3'd1,
    FN_FSET   = 3'd2,
    FN_FCLEAR = 3'd3,
    FN_RESIZE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_en;
    logic [WADDR_W:0]     clr_from;
  } mem_req_t;

endpackage

### hw/rtl/brwf_word_unit.sv
// Shared word unit: masked range update and first-match search within one word.
module brwf_word_unit (
  input  logic [brwf_pkg::WORD_BITS-1:0] word,
  input  logic [brwf_pkg::BSEL_W-1:0]    lo,
  input  logic [brwf_pkg::BSEL_W-1:0]    hi,
  input  logic                           wval,
  input  logic                           match,
  output logic [brwf_pkg::WORD_BITS-1:0] new_word,
  output logic                           hit,
  output logic [brwf_pkg::BSEL_W-1:0]    pos
);

  localparam logic [brwf_pkg::BSEL_W-1:0] TOP_BIT = brwf_pkg::BSEL_W'(brwf_pkg::WORD_BITS - 1);

  logic [brwf_pkg::WORD_BITS-1:0] mask;
  logic [brwf_pkg::WORD_BITS-1:0] cand;

  assign mask     = ({brwf_pkg::WORD_BITS{1'b1}} << lo) &
                    ({brwf_pkg::WORD_BITS{1'b1}} >> (TOP_BIT - hi));
  assign new_word = wval ? (word | mask) : (word & ~mask);
  assign cand     = (match ? word : ~word) & mask;
  assign hit      = |cand;

  always_comb begin
    pos = '0;
    for (int i = brwf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = brwf_pkg::BSEL_W'(i);
      end
    end
  end

endmodule

### hw/rtl/brwf_store.sv
// Word store with one registered read port, one write port and per-word valid bits.
module brwf_store (
  input  logic                           clk,
  input  logic                           rst,
  input  brwf_pkg::mem_req_t             req,
  output logic [brwf_pkg::WORD_BITS-1:0] rd_word
);

  logic [brwf_pkg::WORD_BITS-1:0] mem [brwf_pkg::NUM_WORDS];
  logic [brwf_pkg::NUM_WORDS-1:0] vld;
  logic [brwf_pkg::WORD_BITS-1:0] rdata;
  logic                           rvld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (req.clr_en) begin
        for (int i = 0; i < brwf_pkg::NUM_WORDS; i++) begin
          if ((brwf_pkg::WADDR_W + 1)'(i) >= req.clr_from) begin
            vld[i] <= 1'b0;
          end
        end
      end
      if (req.wr_en) begin
        vld[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld <= vld[req.addr];
      end
    end
  end

  assign rd_word = rvld ? rdata : '0;

endmodule

### hw/rtl/bitmap_range_write_find_first_top.sv
// Top level: request sequencer around the word store and the shared word unit.
//
//   channel | direction | fields (lowest bit first)
//   s_*     | in        | func, first_index, last_index, write_value, new_length
//   m_*     | out       | bit_value, found, found_index, length_now, error
//
// A range write or search visits its words one at a time, each with a read state and then
// an update or test state, through the one address of the word store; a resize, a refused
// request or a test or search from or past the length goes straight to the done state.
// Reset clears the length and all word valid bits at once; no clearing pass.
// A result waits in the output register while the next item is accepted; that item
// then holds in its last cycle until the waiting result is taken.
module bitmap_range_write_find_first_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // func[2:0], first_index[14:3], last_index[26:15], write_value[27],
  // new_length[40:28], zero pad
  input  logic [brwf_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // bit_value[0], found[1], found_index[13:2], length_now[26:14], error[27], zero pad
  output logic [brwf_pkg::OUT_W-1:0]  m_tdata
);

  localparam int IW = brwf_pkg::IDX_W;
  localparam int LW = brwf_pkg::LEN_W;
  localparam int AW = brwf_pkg::WADDR_W;
  localparam int BW = brwf_pkg::BSEL_W;

  brwf_pkg::state_t   state, state_next;
  brwf_pkg::mem_req_t req;

  logic [LW-1:0] bit_count, bit_count_next;

  logic [brwf_pkg::FUNC_W-1:0] in_func;
  logic [IW-1:0]               in_first, in_last;
  logic                        in_wval;
  logic [LW-1:0]               in_newlen, first_ext, last_ext, cnt_m1;
  logic [AW:0]                 new_words;
  logic                        accept, dec_err, dec_go, out_free;

  logic [brwf_pkg::FUNC_W-1:0] op;
  logic [AW-1:0]               cur_word, start_word, end_word;
  logic [BW-1:0]               first_bit, last_bit;
  logic                        wval;
  logic                        res_bit, res_found, res_err;
  logic [IW-1:0]               res_idx;

  logic [brwf_pkg::WORD_BITS-1:0] rd_word, new_word;
  logic [BW-1:0]                  u_lo, u_hi, hit_pos;
  logic                           u_match, hit, is_last, is_search, finish;

  assign in_func   = s_tdata[2:0];
  assign in_first  = s_tdata[14:3];
  assign in_last   = s_tdata[26:15];
  assign in_wval   = s_tdata[27];
  assign in_newlen = s_tdata[40:28];

  assign first_ext = LW'(in_first);
  assign last_ext  = LW'(in_last);
  assign cnt_m1    = bit_count - LW'(1);
  assign new_words = (AW + 1)'((LW + 1)'(in_newlen) + (LW + 1)'(brwf_pkg::WORD_BITS - 1)
                     >> BW);

  assign s_tready = (state == brwf_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    dec_err = 1'b0;
    dec_go  = 1'b0;
    case (in_func)
      brwf_pkg::FN_WRITE: begin
        dec_err = (in_first > in_last) || (last_ext >= brwf_pkg::CAP_LEN);
        dec_go  = !dec_err;
      end
      brwf_pkg::FN_TEST, brwf_pkg::FN_FSET, brwf_pkg::FN_FCLEAR: begin
        dec_err = first_ext >= brwf_pkg::CAP_LEN;
        dec_go  = !dec_err && (first_ext < bit_count);
      end
      brwf_pkg::FN_RESIZE: begin
        dec_err = in_newlen > brwf_pkg::CAP_LEN;
      end
      default: begin
        dec_err = 1'b1;
      end
    endcase
  end

  assign is_search = (op == brwf_pkg::FN_FSET) || (op == brwf_pkg::FN_FCLEAR) ||
                     (op == brwf_pkg::FN_TEST);
  assign is_last   = (cur_word == end_word);
  assign finish    = is_last || ((op != brwf_pkg::FN_WRITE) && hit);
  assign u_lo      = (cur_word == start_word) ? first_bit : '0;
  assign u_hi      = is_last ? last_bit : BW'(brwf_pkg::WORD_BITS - 1);
  assign u_match   = (op != brwf_pkg::FN_FCLEAR);

  brwf_word_unit u_unit (
    .word     (rd_word),
    .lo       (u_lo),
    .hi       (u_hi),
    .wval     (wval),
    .match    (u_match),
    .new_word (new_word),
    .hit      (hit),
    .pos      (hit_pos)
  );

  brwf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_word (rd_word)
  );

  always_comb begin
    state_next = state;
    case (state)
      brwf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = dec_go ? brwf_pkg::ST_RD : brwf_pkg::ST_DONE;
        end
      end
      brwf_pkg::ST_RD: begin
        state_next = brwf_pkg::ST_MOD;
      end
      brwf_pkg::ST_MOD: begin
        state_next = finish ? brwf_pkg::ST_DONE : brwf_pkg::ST_RD;
      end
      brwf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = brwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brwf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req            = '0;
    req.addr       = cur_word;
    req.wr_data    = new_word;
    req.clr_from   = new_words;
    bit_count_next = bit_count;
    case (state)
      brwf_pkg::ST_IDLE: begin
        if (accept && !dec_err) begin
          if (in_func == brwf_pkg::FN_WRITE && last_ext >= bit_count) begin
            bit_count_next = last_ext + LW'(1);
          end
          if (in_func == brwf_pkg::FN_RESIZE && in_newlen != bit_count) begin
            bit_count_next = in_newlen;
            req.clr_en     = 1'b1;
          end
        end
      end
      brwf_pkg::ST_RD: begin
        req.rd_en = 1'b1;
      end
      brwf_pkg::ST_MOD: begin
        req.wr_en = (op == brwf_pkg::FN_WRITE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brwf_pkg::ST_IDLE;
      bit_count <= '0;
    end else begin
      state     <= state_next;
      bit_count <= bit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= in_func;
      wval       <= in_wval;
      first_bit  <= in_first[BW-1:0];
      start_word <= in_first[BW +: AW];
      cur_word   <= in_first[BW +: AW];
      res_bit    <= 1'b0;
      res_found  <= 1'b0;
      res_idx    <= '0;
      res_err    <= dec_err;
      if (in_func == brwf_pkg::FN_WRITE) begin
        end_word <= in_last[BW +: AW];
        last_bit <= in_last[BW-1:0];
      end else if (in_func == brwf_pkg::FN_TEST) begin
        end_word <= in_first[BW +: AW];
        last_bit <= in_first[BW-1:0];
      end else begin
        end_word <= cnt_m1[BW +: AW];
        last_bit <= cnt_m1[BW-1:0];
      end
    end else if (state == brwf_pkg::ST_MOD) begin
      cur_word <= cur_word + AW'(1);
      if (is_search && hit) begin
        if (op == brwf_pkg::FN_TEST) begin
          res_bit <= 1'b1;
        end else begin
          res_found <= 1'b1;
          res_idx   <= {cur_word, hit_pos};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == brwf_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == brwf_pkg::ST_DONE && out_free) begin
      m_tdata <= {4'b0, res_err, bit_count, res_idx, res_found, res_bit};
    end
  end

endmodule

### hw/rtl/brwf_checker.sv
// Port-level checks for the bitmap block, bound to the top level.
module brwf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [brwf_pkg::OUT_W-1:0] m_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again in the cycle after an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_hit_in_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> ({1'b0, m_tdata[13:2]} < m_tdata[26:14]))
    else $error("search hit at or beyond the length");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[27]) |-> (!m_tdata[0] && !m_tdata[1] && m_tdata[13:2] == '0))
    else $error("refused request carries result fields");

endmodule

bind bitmap_range_write_find_first_top brwf_checker u_brwf_checker (.*);

### sim/tb.sv
// Self-checking testbench for the bitmap range write and find-first block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brwf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int N_RANDOM    = 1900;

  typedef struct packed {
    logic [LEN_W-1:0] new_length;
    logic             write_value;
    logic [IDX_W-1:0] last_index;
    logic [IDX_W-1:0] first_index;
    logic [FUNC_W-1:0] func;
  } req_t;

  typedef struct packed {
    logic             error;
    logic [LEN_W-1:0] length_now;
    logic [IDX_W-1:0] found_index;
    logic             found;
    logic             bit_value;
  } result_t;

  typedef struct {
    req_t req;
    bit   drain;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  req_t cur = '0;
  logic [IN_W-1:0] s_tdata;

  assign s_tdata = {{(IN_W - $bits(req_t)){1'b0}}, cur};

  bitmap_range_write_find_first_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [WORD_BITS-1:0] bm_words [NUM_WORDS];
  logic [LEN_W-1:0]     bm_len;
  slot_t   req_backlog[$];
  result_t results_due[$];
  result_t due, got;
  int  gen_len = 0;
  int  cycles = 0;
  int  stall = 0;
  int  hold_left = 0;
  int  errors = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_hits = 0;
  int  n_refused = 0;
  int  func_seen [8];
  bit  in_fire = 1'b0;
  wire calm = (cycles >= 5000) && (cycles < 9000);

  function automatic result_t bitmap_apply(input req_t r);
    result_t     res;
    int unsigned i;
    int unsigned w;
    logic        want;
    res = '0;
    func_seen[r.func]++;
    case (r.func)
      FN_WRITE: begin
        if (r.first_index > r.last_index || int'(r.last_index) >= CAP_BITS) begin
          res.error = 1'b1;
        end else begin
          if ({1'b0, r.last_index} >= bm_len) bm_len = LEN_W'(r.last_index) + LEN_W'(1);
          for (i = r.first_index; i <= r.last_index; i++)
            bm_words[i / WORD_BITS][i % WORD_BITS] = r.write_value;
        end
      end
      FN_TEST: begin
        if (int'(r.first_index) >= CAP_BITS) res.error = 1'b1;
        else if (r.first_index < bm_len)
          res.bit_value = bm_words[r.first_index / WORD_BITS][r.first_index % WORD_BITS];
      end
      FN_FSET, FN_FCLEAR: begin
        if (int'(r.first_index) >= CAP_BITS) begin
          res.error = 1'b1;
        end else begin
          want = (r.func == FN_FSET);
          for (i = r.first_index; i < bm_len && !res.found; i++) begin
            if (bm_words[i / WORD_BITS][i % WORD_BITS] == want) begin
              res.found = 1'b1;
              res.found_index = i[IDX_W-1:0];
            end
          end
        end
      end
      FN_RESIZE: begin
        if (int'(r.new_length) > CAP_BITS) begin
          res.error = 1'b1;
        end else if (r.new_length != bm_len) begin
          for (w = (r.new_length + WORD_BITS - 1) / WORD_BITS; w < NUM_WORDS; w++)
            bm_words[w] = '0;
          bm_len = r.new_length;
        end
      end
      default: res.error = 1'b1;
    endcase
    res.length_now = bm_len;
    return res;
  endfunction

  task automatic add_req(input logic [FUNC_W-1:0] fn, input int first, input int last,
                         input logic wv, input int len);
    slot_t s;
    s.drain = 1'b0;
    s.req.func = fn;
    s.req.first_index = first[IDX_W-1:0];
    s.req.last_index = last[IDX_W-1:0];
    s.req.write_value = wv;
    s.req.new_length = len[LEN_W-1:0];
    req_backlog.push_back(s);
    if (fn == FN_WRITE && first <= last && last + 1 > gen_len) gen_len = last + 1;
    if (fn == FN_RESIZE && len <= CAP_BITS) gen_len = len;
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire = s_tvalid && s_tready;
    if (!rst) begin
      if (in_fire) begin
        results_due.push_back(bitmap_apply(cur));
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result %0h arrived with nothing expected", $time, m_tdata);
          errors++;
        end else begin
          due = results_due.pop_front();
          got = result_t'(m_tdata[$bits(result_t)-1:0]);
          n_checked++;
          if (due.found) n_hits++;
          if (due.error) n_refused++;
          if (got.bit_value != due.bit_value) report("bit_value", due.bit_value, got.bit_value);
          if (got.found != due.found) report("found", due.found, got.found);
          if (got.found_index != due.found_index)
            report("found_index", due.found_index, got.found_index);
          if (got.length_now != due.length_now)
            report("length_now", due.length_now, got.length_now);
          if (got.error != due.error) report("error", due.error, got.error);
          if (m_tdata[OUT_W-1:$bits(result_t)] != '0)
            report("pad", '0, m_tdata[OUT_W-1:$bits(result_t)]);
        end
      end
      stall <= (in_fire || (m_tvalid && m_tready)) ? 0 : stall + 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_fire)) begin
      if (req_backlog.size() > 0 && req_backlog[0].drain) begin
        s_tvalid <= 1'b0;
        if (results_due.size() == 0) void'(req_backlog.pop_front());
      end else if (req_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        cur <= req_backlog[0].req;
        void'(req_backlog.pop_front());
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (cycles == 2500 || cycles == 30000) begin
      hold_left <= HOLD_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 13;
    end
  end

  initial begin
    while (stall < STALL_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int    k, pick, span, top, f, l, nl;
    logic [FUNC_W-1:0] fn;
    slot_t pause;
    for (k = 0; k < NUM_WORDS; k++) bm_words[k] = '0;
    for (k = 0; k < 8; k++) func_seen[k] = 0;
    bm_len = '0;
    pause.req = '0;
    pause.drain = 1'b1;

    add_req(FN_TEST, 0, 0, 0, 0);
    add_req(FN_FSET, 0, 0, 0, 0);
    add_req(FN_WRITE, 0, 4095, 1, 0);
    add_req(FN_FCLEAR, 0, 0, 0, 0);
    add_req(FN_FSET, 4095, 0, 0, 0);
    add_req(FN_TEST, 4095, 0, 0, 0);
    add_req(FN_WRITE, 100, 100, 0, 0);
    add_req(FN_FCLEAR, 0, 0, 0, 0);
    add_req(FN_WRITE, 10, 5, 1, 0);
    add_req(FN_RESIZE, 0, 0, 0, 4097);
    add_req(FN_RESIZE, 0, 0, 0, 8191);
    add_req(FN_RESIZE, 0, 0, 0, 70);
    add_req(FN_TEST, 100, 0, 0, 0);
    add_req(FN_FSET, 70, 0, 0, 0);
    add_req(FN_FCLEAR, 60, 0, 0, 0);
    add_req(FN_RESIZE, 0, 0, 0, 128);
    add_req(FN_FSET, 70, 0, 0, 0);
    add_req(FN_RESIZE, 0, 0, 0, 128);
    for (k = 1; k <= 3; k++) add_req(FN_RESIZE + 3'(k), 5, 9, 1, 300);
    add_req(FN_RESIZE, 0, 0, 0, 0);
    add_req(FN_FCLEAR, 0, 0, 0, 0);
    add_req(FN_WRITE, 63, 64, 1, 0);
    add_req(FN_WRITE, 0, 4095, 0, 0);
    add_req(FN_FCLEAR, 4095, 0, 0, 4096);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 500 || k == 1200) req_backlog.push_back(pause);
      pick = $urandom_range(0, 99);
      if (pick < 30) fn = FN_WRITE;
      else if (pick < 50) fn = FN_TEST;
      else if (pick < 67) fn = FN_FSET;
      else if (pick < 84) fn = FN_FCLEAR;
      else if (pick < 94) fn = FN_RESIZE;
      else fn = FN_RESIZE + 3'($urandom_range(1, 3));
      top = (gen_len + 64 > 4095) ? 4095 : gen_len + 64;
      f = ($urandom_range(0, 9) < 6) ? $urandom_range(0, top) : $urandom_range(0, 4095);
      l = $urandom_range(0, 4095);
      nl = $urandom_range(0, 8191);
      if (fn == FN_WRITE) begin
        pick = $urandom_range(0, 99);
        span = (pick < 70) ? $urandom_range(0, 15) :
               (pick < 90) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
        l = (f + span > 4095) ? 4095 : f + span;
        if ($urandom_range(0, 19) == 0 && f > 0) l = $urandom_range(0, f - 1);
      end else if (fn == FN_RESIZE) begin
        pick = $urandom_range(0, 99);
        top = (gen_len + 200 > CAP_BITS) ? CAP_BITS : gen_len + 200;
        if (pick < 50) nl = $urandom_range(0, top);
        else if (pick < 80) nl = $urandom_range(0, CAP_BITS);
        else if (pick < 90) nl = $urandom_range(CAP_BITS + 1, 8191);
        else nl = gen_len;
      end
      add_req(fn, f, l, $urandom_range(0, 1), nl);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() > 0 || s_tvalid || results_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d writes, %0d tests, %0d set and %0d clear searches,",
             n_accepted, func_seen[FN_WRITE], func_seen[FN_TEST], func_seen[FN_FSET],
             func_seen[FN_FCLEAR]);
    $display("%0d resizes; %0d results checked, %0d search hits, %0d refused, %0d errors.",
             func_seen[FN_RESIZE], n_checked, n_hits, n_refused, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
